// ===== rtl/sfpd_pkg.sv =====
// Package for the framed packet deframer.
// Holds the parse phase type, the result struct, framing constants and the CRC helper.
// No dependencies.
package sfpd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned CRC_W     = 16;
    localparam int unsigned CNT_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [BYTE_W-1:0] START_FIRST  = 8'hA5;
    localparam logic [BYTE_W-1:0] START_SECOND = 8'h5A;
    localparam logic [CRC_W-1:0]  CRC_INIT     = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_TOP      = 16'h8000;
    localparam logic [CRC_W-1:0]  CRC_POLY     = 16'h1021;

    localparam logic [BYTE_W-1:0] EXP_VERSION_RST = 8'd1;
    localparam logic [LEN_W-1:0]  MAX_LENGTH_RST  = 16'd908;

    localparam logic [CFG_IDX_W-1:0] CFG_EXP_VERSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH  = 2'd1;

    localparam logic [1:0] HDR_VERSION = 2'd0;
    localparam logic [1:0] HDR_TYPE    = 2'd1;
    localparam logic [1:0] HDR_LEN_LO  = 2'd2;
    localparam logic [1:0] HDR_LEN_HI  = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_HEADER  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4
    } t_phase;

    typedef struct packed {
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  payload_index;
        logic              frame_done;
        logic              frame_good;
        logic [BYTE_W-1:0] message_type;
        logic [LEN_W-1:0]  frame_length;
        logic              header_rejected;
        logic [CNT_W-1:0]  crc_error_total;
        logic [CNT_W-1:0]  resync_total;
    } t_result;

    // One byte of CRC-16/CCITT-FALSE, MSB first, eight shift steps.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            if ((c & CRC_TOP) != '0) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/sfpd_if.sv =====
// Handshake interfaces of the framed packet deframer: byte input, result output
// and register write channel. Depends on sfpd_pkg.
interface sfpd_byte_if import sfpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfpd_res_if import sfpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic [LEN_W-1:0]  payload_index;
    logic              frame_done;
    logic              frame_good;
    logic [BYTE_W-1:0] message_type;
    logic [LEN_W-1:0]  frame_length;
    logic              header_rejected;
    logic [CNT_W-1:0]  crc_error_total;
    logic [CNT_W-1:0]  resync_total;
    modport source (output valid, output payload_valid, output payload_byte,
                    output payload_index, output frame_done, output frame_good,
                    output message_type, output frame_length, output header_rejected,
                    output crc_error_total, output resync_total, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input payload_index, input frame_done, input frame_good,
                    input message_type, input frame_length, input header_rejected,
                    input crc_error_total, input resync_total, output ready);
endinterface

interface sfpd_cfg_if import sfpd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sync_framed_packet_deframer_crc16.sv =====
// Top level of the framed packet deframer: start-pair hunt, header check,
// payload pass-through and CRC-16/CCITT-FALSE check. Depends on sfpd_pkg, sfpd_if.
// The result is registered: it appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while results are taken; a held result stalls input.
// The parse state and byte-wide CRC update are combinational; one register holds the result.
// Reset (synchronous, active low) returns to hunting, clears counters and loads
// the register defaults (version 1, length limit 908).
module sync_framed_packet_deframer_crc16 import sfpd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sfpd_byte_if.sink   i_rx,
    sfpd_res_if.source  o_res,
    sfpd_cfg_if.sink    i_cfg
);

    // Configuration registers. Writes are always taken; unknown indexes drop.
    logic [BYTE_W-1:0] r_exp_version;
    logic [LEN_W-1:0]  r_max_length;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_version <= EXP_VERSION_RST;
            r_max_length  <= MAX_LENGTH_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_EXP_VERSION: r_exp_version <= i_cfg.data[BYTE_W-1:0];
                CFG_MAX_LENGTH:  r_max_length  <= i_cfg.data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Parse state. Everything here advances only when a byte is accepted.
    t_phase            r_phase,     n_phase;
    logic [1:0]        r_hdr_cnt,   n_hdr_cnt;
    logic [BYTE_W-1:0] r_version,   n_version;
    logic [BYTE_W-1:0] r_type,      n_type;
    logic [BYTE_W-1:0] r_len_lo,    n_len_lo;
    logic [LEN_W-1:0]  r_len,       n_len;
    logic [LEN_W-1:0]  r_pay_cnt,   n_pay_cnt;
    logic [BYTE_W-1:0] r_chk_lo,    n_chk_lo;
    logic              r_chk_cnt,   n_chk_cnt;
    logic [CRC_W-1:0]  r_crc,       n_crc;
    logic [CNT_W-1:0]  r_crc_err,   n_crc_err;
    logic [CNT_W-1:0]  r_resync,    n_resync;

    // Output register, which lets a new byte in while the last result is taken.
    t_result r_res, n_res;
    logic    r_res_valid;

    logic              in_fire;
    logic [BYTE_W-1:0] b;
    logic [LEN_W-1:0]  hdr_len;
    logic              hdr_reject;
    logic [LEN_W-1:0]  pay_cnt_inc;
    logic [CRC_W-1:0]  crc_upd;

    assign i_rx.ready = !r_res_valid || o_res.ready;
    assign in_fire    = i_rx.valid && i_rx.ready;
    assign b          = i_rx.rx_byte;

    // Decode used by the phase logic and the datapath; crc_upd is used by the datapath only.
    assign hdr_len     = {b, r_len_lo};
    assign hdr_reject  = (r_hdr_cnt == HDR_LEN_HI) &&
                         ((r_version != r_exp_version) || (hdr_len > r_max_length));
    assign pay_cnt_inc = r_pay_cnt + 1'b1;
    assign crc_upd     = crc_byte(r_crc, b);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_HUNT2: begin
                if (b == START_SECOND) begin
                    n_phase = PH_HEADER;
                end else if (b != START_FIRST) begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_HEADER: begin
                if (r_hdr_cnt == HDR_LEN_HI) begin
                    if (hdr_reject) begin
                        n_phase = PH_HUNT1;
                    end else if (hdr_len != '0) begin
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_phase = PH_CHECK;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (pay_cnt_inc == r_len) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                if (r_chk_cnt) begin
                    n_phase = PH_HUNT1;
                end
            end
            default: begin
                // Hunting for the first start byte, and any unused phase code.
                n_phase = (b == START_FIRST) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    // Datapath and result fields.
    always_comb begin
        n_hdr_cnt = r_hdr_cnt;
        n_version = r_version;
        n_type    = r_type;
        n_len_lo  = r_len_lo;
        n_len     = r_len;
        n_pay_cnt = r_pay_cnt;
        n_chk_lo  = r_chk_lo;
        n_chk_cnt = r_chk_cnt;
        n_crc     = r_crc;
        n_crc_err = r_crc_err;
        n_resync  = r_resync;
        n_res     = '0;

        case (r_phase)
            PH_HUNT2: begin
                if (b == START_SECOND) begin
                    n_hdr_cnt = '0;
                    n_crc     = CRC_INIT;
                end
            end
            PH_HEADER: begin
                n_crc = crc_upd;
                case (r_hdr_cnt)
                    HDR_VERSION: n_version = b;
                    HDR_TYPE:    n_type    = b;
                    HDR_LEN_LO:  n_len_lo  = b;
                    default: begin
                        n_len     = hdr_len;
                        n_pay_cnt = '0;
                        n_chk_cnt = 1'b0;
                        if (hdr_reject) begin
                            n_hdr_cnt            = '0;
                            n_resync             = r_resync + 1'b1;
                            n_res.header_rejected = 1'b1;
                        end
                    end
                endcase
                if (r_hdr_cnt != HDR_LEN_HI) begin
                    n_hdr_cnt = r_hdr_cnt + 1'b1;
                end
            end
            PH_PAYLOAD: begin
                n_crc               = crc_upd;
                n_pay_cnt           = pay_cnt_inc;
                n_res.payload_valid = 1'b1;
                n_res.payload_byte  = b;
                n_res.payload_index = r_pay_cnt;
                if (pay_cnt_inc == r_len) begin
                    n_chk_cnt = 1'b0;
                end
            end
            PH_CHECK: begin
                if (!r_chk_cnt) begin
                    n_chk_lo  = b;
                    n_chk_cnt = 1'b1;
                end else begin
                    n_res.frame_done = 1'b1;
                    if ({b, r_chk_lo} == r_crc) begin
                        n_res.frame_good = 1'b1;
                    end else begin
                        n_crc_err = r_crc_err + 1'b1;
                    end
                    n_hdr_cnt = '0;
                    n_pay_cnt = '0;
                    n_chk_cnt = 1'b0;
                end
            end
            default: ;
        endcase

        // Header fields and totals report the state after this byte.
        n_res.message_type    = n_type;
        n_res.frame_length    = n_len;
        n_res.crc_error_total = n_crc_err;
        n_res.resync_total    = n_resync;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT1;
            r_hdr_cnt <= '0;
            r_version <= '0;
            r_type    <= '0;
            r_len_lo  <= '0;
            r_len     <= '0;
            r_pay_cnt <= '0;
            r_chk_lo  <= '0;
            r_chk_cnt <= 1'b0;
            r_crc     <= CRC_INIT;
            r_crc_err <= '0;
            r_resync  <= '0;
        end else if (in_fire) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_version <= n_version;
            r_type    <= n_type;
            r_len_lo  <= n_len_lo;
            r_len     <= n_len;
            r_pay_cnt <= n_pay_cnt;
            r_chk_lo  <= n_chk_lo;
            r_chk_cnt <= n_chk_cnt;
            r_crc     <= n_crc;
            r_crc_err <= n_crc_err;
            r_resync  <= n_resync;
        end
    end

    // Result register: loads on every accepted byte, empties when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (in_fire) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid           = r_res_valid;
    assign o_res.payload_valid   = r_res.payload_valid;
    assign o_res.payload_byte    = r_res.payload_byte;
    assign o_res.payload_index   = r_res.payload_index;
    assign o_res.frame_done      = r_res.frame_done;
    assign o_res.frame_good      = r_res.frame_good;
    assign o_res.message_type    = r_res.message_type;
    assign o_res.frame_length    = r_res.frame_length;
    assign o_res.header_rejected = r_res.header_rejected;
    assign o_res.crc_error_total = r_res.crc_error_total;
    assign o_res.resync_total    = r_res.resync_total;

endmodule
